FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is asserted.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CHK_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	`CHK_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	`CHK_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

FILE: hdl/cgre_pkg.sv
// ----------------------------------------------------------------------------
// cgre_pkg
// Constants and types shared by the character-group RSA encryption block.
// ----------------------------------------------------------------------------
package cgre_pkg;

	localparam int GROUP_CHARS = 3;
	localparam int CHAR_RADIX  = 256;
	localparam int MOD_BITS    = 18;

	localparam int BYTE_W    = 8;
	localparam int COUNT_W   = 2;
	localparam int VALUE_W   = 24;
	localparam int CFG_W     = 18;
	localparam int CFG_IDX_W = 1;
	// key registers keep only the bits the modulus width allows
	localparam int KEY_W     = (MOD_BITS < CFG_W) ? MOD_BITS : CFG_W;
	localparam int STEP_W    = $clog2(VALUE_W);
	localparam int EXP_CNT_W = $clog2(KEY_W);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

	localparam logic [KEY_W-1:0] EXPONENT_RESET = KEY_W'(1);
	localparam logic [KEY_W-1:0] MODULUS_RESET  = KEY_W'(2);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_REDUCE = 6'b000010,
		ST_LOAD   = 6'b000100,
		ST_MUL    = 6'b001000,
		ST_COMMIT = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	typedef struct packed {
		logic pack;      // take one text byte into the open group
		logic red_step;  // one bit of the base reduction
		logic mul_load;  // clear products, load multiplier scan
		logic mul_step;  // one multiplier bit for both products
		logic commit;    // take products, advance exponent
		logic emit;      // load the output register, close the group
	} dp_cmd_t;

	typedef struct packed {
		logic close;     // the offered byte closes the group
		logic out_free;  // output register can take a word
	} dp_stat_t;

endpackage

FILE: hdl/cgre_ctrl.sv
// ----------------------------------------------------------------------------
// cgre_ctrl
// Sequencer for packing, base reduction and square-and-multiply.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cgre_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  cgre_pkg::dp_stat_t stat,
	output cgre_pkg::dp_cmd_t  cmd
);
	import cgre_pkg::*;

	state_t               state_q, state_d;
	logic [STEP_W-1:0]    step_cnt_q, step_cnt_d;
	logic [EXP_CNT_W-1:0] exp_cnt_q, exp_cnt_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d    = state_q;
		step_cnt_d = step_cnt_q;
		exp_cnt_d  = exp_cnt_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.pack = 1'b1;
					if (stat.close) begin
						state_d    = ST_REDUCE;
						step_cnt_d = STEP_W'(VALUE_W - 1);
						exp_cnt_d  = EXP_CNT_W'(KEY_W - 1);
					end
				end
			end
			ST_REDUCE: begin
				cmd.red_step = 1'b1;
				step_cnt_d   = step_cnt_q - STEP_W'(1);
				if (step_cnt_q == '0)
					state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.mul_load = 1'b1;
				step_cnt_d   = STEP_W'(KEY_W - 1);
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				step_cnt_d   = step_cnt_q - STEP_W'(1);
				if (step_cnt_q == '0)
					state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				if (exp_cnt_q == '0) begin
					state_d = ST_EMIT;
				end else begin
					exp_cnt_d = exp_cnt_q - EXP_CNT_W'(1);
					state_d   = ST_LOAD;
				end
			end
			ST_EMIT: begin
				// hold until the output register frees up
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_cnt_q <= '0;
			exp_cnt_q  <= '0;
		end else begin
			state_q    <= state_d;
			step_cnt_q <= step_cnt_d;
			exp_cnt_q  <= exp_cnt_d;
		end
	end

	`CHK_NEXT(a_close_starts_reduce, clk, arst_n, cmd.pack && stat.close, state_q == ST_REDUCE && step_cnt_q == STEP_W'(VALUE_W - 1), "closing byte did not start reduction")
	`CHK_NEXT(a_commit_loops, clk, arst_n, state_q == ST_COMMIT && exp_cnt_q != '0, state_q == ST_LOAD && exp_cnt_q == $past(exp_cnt_q) - EXP_CNT_W'(1), "exponent loop did not advance")

endmodule

FILE: hdl/cgre_dp.sv
// ----------------------------------------------------------------------------
// cgre_dp
// Key registers, group packer, two bit-serial modular multipliers, output word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cgre_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [cgre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cgre_pkg::CFG_W-1:0]     cfg_data,
	input  logic [cgre_pkg::BYTE_W-1:0]    text_byte,
	input  logic                          final_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cgre_pkg::CFG_W-1:0]     cipher_word,
	output logic [cgre_pkg::COUNT_W-1:0]   bytes_in_group,
	input  cgre_pkg::dp_cmd_t              cmd,
	output cgre_pkg::dp_stat_t             stat
);
	import cgre_pkg::*;

	localparam logic [VALUE_W-1:0] RADIX    = VALUE_W'(CHAR_RADIX);
	localparam logic [COUNT_W-1:0] GROUP_CT = COUNT_W'(GROUP_CHARS);

	// (2r + a) mod n for r, a below n
	function automatic logic [KEY_W-1:0] mod_step(input logic [KEY_W-1:0] r,
			input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] n);
		logic [KEY_W+1:0] t, n1, n2, d1, d2;
		t  = {1'b0, r, 1'b0} + {2'b00, a};
		n1 = {2'b00, n};
		n2 = {1'b0, n, 1'b0};
		d1 = t - n1;
		d2 = t - n2;
		if (t >= n2)
			return d2[KEY_W-1:0];
		else if (t >= n1)
			return d1[KEY_W-1:0];
		else
			return t[KEY_W-1:0];
	endfunction

	logic [KEY_W-1:0]   exp_q, mod_q;
	logic [VALUE_W-1:0] grp_value_q;
	logic [COUNT_W-1:0] grp_count_q;
	logic [KEY_W-1:0]   base_q, acc_q, pa_q, pb_q, scan_q, exp_sh_q;
	logic               out_valid_q;
	logic [CFG_W-1:0]   cipher_q;
	logic [COUNT_W-1:0] bytes_q;

	logic [VALUE_W-1:0] grp_next;
	logic [COUNT_W-1:0] cnt_next;
	logic               scan_bit;
	logic [KEY_W-1:0]   add_a, add_b, r_b, prod_a, prod_b;

	assign grp_next = grp_value_q * RADIX + VALUE_W'(text_byte);
	assign cnt_next = grp_count_q + COUNT_W'(1);

	assign stat.close    = (cnt_next >= GROUP_CT) || final_byte;
	assign stat.out_free = !out_valid_q || !out_stall;

	assign scan_bit = scan_q[KEY_W-1];
	assign add_a    = scan_bit ? acc_q : '0;
	// the second unit also does the reduction, one packed bit a step
	assign r_b      = cmd.red_step ? base_q : pb_q;
	assign add_b    = cmd.red_step ? KEY_W'(grp_value_q[VALUE_W-1]) :
	                  (scan_bit ? base_q : '0);
	assign prod_a   = mod_step(pa_q, add_a, mod_q);
	assign prod_b   = mod_step(r_b, add_b, mod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q       <= EXPONENT_RESET;
			mod_q       <= MODULUS_RESET;
			grp_value_q <= '0;
			grp_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_EXPONENT: exp_q <= cfg_data[KEY_W-1:0];
					REG_MODULUS:  mod_q <= cfg_data[KEY_W-1:0];
					default: ;
				endcase
			end
			if (cmd.pack) begin
				grp_value_q <= grp_next;
				grp_count_q <= cnt_next;
			end else if (cmd.red_step) begin
				grp_value_q <= {grp_value_q[VALUE_W-2:0], 1'b0};
			end else if (cmd.emit) begin
				grp_value_q <= '0;
				grp_count_q <= '0;
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pack) begin
			base_q   <= '0;
			acc_q    <= KEY_W'(1);
			exp_sh_q <= exp_q;
		end
		if (cmd.red_step)
			base_q <= prod_b;
		if (cmd.mul_load) begin
			pa_q   <= '0;
			pb_q   <= '0;
			scan_q <= base_q;
		end
		if (cmd.mul_step) begin
			pa_q   <= prod_a;
			pb_q   <= prod_b;
			scan_q <= {scan_q[KEY_W-2:0], 1'b0};
		end
		if (cmd.commit) begin
			if (exp_sh_q[0])
				acc_q <= pa_q;
			base_q   <= pb_q;
			exp_sh_q <= {1'b0, exp_sh_q[KEY_W-1:1]};
		end
		if (cmd.emit) begin
			// a modulus below two gives zero
			cipher_q <= (mod_q < KEY_W'(2)) ? '0 : CFG_W'(acc_q);
			bytes_q  <= grp_count_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign cipher_word    = cipher_q;
	assign bytes_in_group = bytes_q;

	`CHK_NEXT(a_emit_clears_group, clk, arst_n, cmd.emit, out_valid_q && grp_count_q == '0 && grp_value_q == '0, "emit did not load word and clear group")
	`CHK_IMPLIES(a_result_reduced, clk, arst_n, cmd.emit && mod_q >= KEY_W'(2), acc_q < mod_q, "result not below modulus")

endmodule

FILE: hdl/char_group_rsa_encrypt.sv
// ----------------------------------------------------------------------------
// char_group_rsa_encrypt
// Packs text bytes into groups and encrypts each group as m^e mod n.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    text_byte, final_byte
// out       output     out_valid / out_stall  cipher_word, bytes_in_group
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A byte that leaves its group open is packed while the block is idle.
// A closing byte starts the base reduction, then for each of the K = 18 exponent
// bits a load, multiply and commit on the two bit-serial modular multipliers,
// one multiplier bit per cycle, that form product and square together.
// in_stall stays high from a closing byte until its word enters the output
// register; a stalled output word holds that register and delays the next one.
// Reset sets exponent 1, modulus 2 and an empty group.
// ----------------------------------------------------------------------------
module char_group_rsa_encrypt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cgre_pkg::BYTE_W-1:0]    text_byte,
	input  logic                          final_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cgre_pkg::CFG_W-1:0]     cipher_word,
	output logic [cgre_pkg::COUNT_W-1:0]   bytes_in_group,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cgre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cgre_pkg::CFG_W-1:0]     cfg_data
);
	import cgre_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	cgre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	cgre_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.text_byte      (text_byte),
		.final_byte     (final_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cipher_word    (cipher_word),
		.bytes_in_group (bytes_in_group),
		.cmd            (cmd),
		.stat           (stat)
	);

endmodule
